@@ sv/teq_pkg.sv @@
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants for the timer expiry queue.
// ----------------------------------------------------------------------------
package teq_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // Most timers reported by one tick, and the widths of its list.
  localparam int unsigned MaxResults = 16;
  localparam int unsigned ResIdxW    = 4;
  localparam int unsigned ResCntW    = 5;

  typedef struct packed {
    op_e         op;
    logic [31:0] tid;
    logic [63:0] exp;
    logic [63:0] intv;
    logic [63:0] now;
  } cmd_t;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_ADD_SCAN  = 7'b0000010,
    ST_CAN_SCAN  = 7'b0000100,
    ST_PICK_SCAN = 7'b0001000,
    ST_PICK_DONE = 7'b0010000,
    ST_MIN_SCAN  = 7'b0100000,
    ST_EMIT      = 7'b1000000
  } state_e;

endpackage

@@ sv/teq_ram.sv @@
// ----------------------------------------------------------------------------
// teq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module teq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/teq_front.sv @@
// ----------------------------------------------------------------------------
// teq_front
// Accepts input words, decodes the opcode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module teq_front
  import teq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] timer_id_i,
  input  logic [63:0] expire_at_i,
  input  logic [63:0] repeat_interval_i,
  input  logic [63:0] now_time_i,
  output logic        cmd_vld_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t       buf_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr, rd;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in      = '0;
    case (opcode_i)
      2'd0:    cmd_in.op = OP_ADD;
      2'd1:    cmd_in.op = OP_CANCEL;
      2'd2:    cmd_in.op = OP_TICK;
      default: cmd_in.op = OP_NONE;
    endcase
    cmd_in.tid  = timer_id_i;
    cmd_in.exp  = expire_at_i;
    cmd_in.intv = repeat_interval_i;
    cmd_in.now  = now_time_i;
  end

  assign full      = (cnt_q == 2'd2);
  assign cmd_vld_o = (cnt_q != 2'd0);
  assign cmd_o     = buf_q[rptr_q];
  assign wr        = push && !full;
  assign rd        = cmd_pop_i && cmd_vld_o;

  always_comb begin
    wptr_d = wr ? !wptr_q : wptr_q;
    rptr_d = rd ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wptr_q] <= cmd_in;
    end
  end

endmodule

@@ sv/teq_back.sv @@
// ----------------------------------------------------------------------------
// teq_back
// Timer table engine: scans the slot RAMs one or more times per step and emits results.
// ----------------------------------------------------------------------------
module teq_back
  import teq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_vld_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [1:0]  status_o,
  output logic [31:0] result_id_o,
  output logic        armed_o,
  output logic [63:0] next_deadline_o,
  output logic        last_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  cmd_t              cmd_q;
  logic [31:0]       idc_q, idc_d, cur_id_q, cur_id_d;
  logic [DEPTH-1:0]  valid_q, valid_d, picked_q, picked_d;
  logic              found_q, found_d, dup_q, dup_d;
  logic [IW-1:0]     bidx_q, bidx_d;
  logic [63:0]       bexp_q, bexp_d, bint_q, bint_d;
  logic [31:0]       bid_q, bid_d;

  logic [31:0]       res_id_q   [MaxResults];
  logic              res_kind_q [MaxResults];
  logic [1:0]        res_stat_q [MaxResults];
  logic [ResCntW-1:0] nres_q, nres_d, eidx_q, eidx_d;
  logic              res_we;
  logic [31:0]       res_wid;
  logic              res_wkind;
  logic [1:0]        res_wstat;
  logic              armed_q, armed_d;
  logic [63:0]       dl_q, dl_d;

  logic              out_vld_q, out_ld, out_last;
  logic              out_kind_q, out_last_q;
  logic [1:0]        out_stat_q;
  logic [31:0]       out_id_q;
  logic [63:0]       out_dl_q;
  logic              out_armed_q;

  logic [IW-1:0]     raddr, waddr, pidx;
  logic              proc, scan_last;
  logic [63:0]       exp_rd, int_rd, exp_wd;
  logic [31:0]       id_rd;
  logic              exp_we, int_we, id_we;
  logic [64:0]       rearm_sum;
  logic              elig, key_less;

  assign scan_last = (cnt_q == CW'(DEPTH));
  assign proc      = (cnt_q != '0);
  assign pidx      = IW'(cnt_q - CW'(1));
  assign raddr     = scan_last ? '0 : cnt_q[IW-1:0];
  assign rearm_sum = {1'b0, cmd_q.now} + {1'b0, bint_q};
  assign elig      = valid_q[pidx] && !picked_q[pidx] && (exp_rd <= cmd_q.now);
  assign key_less  = (exp_rd < bexp_q) || ((exp_rd == bexp_q) && (id_rd < bid_q));

  teq_ram #(.Width(64), .Depth(DEPTH)) u_exp_ram (
    .clk_i, .we_i(exp_we), .waddr_i(waddr), .wdata_i(exp_wd),
    .raddr_i(raddr), .rdata_o(exp_rd)
  );
  teq_ram #(.Width(64), .Depth(DEPTH)) u_int_ram (
    .clk_i, .we_i(int_we), .waddr_i(waddr), .wdata_i(cmd_q.intv),
    .raddr_i(raddr), .rdata_o(int_rd)
  );
  teq_ram #(.Width(32), .Depth(DEPTH)) u_id_ram (
    .clk_i, .we_i(id_we), .waddr_i(waddr), .wdata_i(cur_id_q),
    .raddr_i(raddr), .rdata_o(id_rd)
  );

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_vld_i;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idc_d     = idc_q;
    cur_id_d  = cur_id_q;
    valid_d   = valid_q;
    picked_d  = picked_q;
    found_d   = found_q;
    dup_d     = dup_q;
    bidx_d    = bidx_q;
    bexp_d    = bexp_q;
    bint_d    = bint_q;
    bid_d     = bid_q;
    nres_d    = nres_q;
    eidx_d    = eidx_q;
    armed_d   = armed_q;
    dl_d      = dl_q;
    res_we    = 1'b0;
    res_wid   = '0;
    res_wkind = KIND_STATUS;
    res_wstat = STAT_OK;
    exp_we    = 1'b0;
    int_we    = 1'b0;
    id_we     = 1'b0;
    waddr     = bidx_q;
    exp_wd    = cmd_q.exp;
    out_ld    = 1'b0;
    out_last  = (eidx_q == nres_q - ResCntW'(1));

    case (state_q)
      ST_IDLE: begin
        cnt_d   = '0;
        found_d = 1'b0;
        dup_d   = 1'b0;
        nres_d  = '0;
        eidx_d  = '0;
        if (cmd_vld_i) begin
          case (cmd_i.op)
            OP_ADD: begin
              // take the id now, and advance the counter, skipping zero
              cur_id_d = idc_q;
              idc_d    = (idc_q == 32'hFFFF_FFFF) ? 32'd1 : idc_q + 32'd1;
              state_d  = ST_ADD_SCAN;
            end
            OP_CANCEL: state_d = ST_CAN_SCAN;
            OP_TICK: begin
              picked_d = '0;
              state_d  = ST_PICK_SCAN;
            end
            default: begin
              res_we  = 1'b1;
              nres_d  = ResCntW'(1);
              state_d = ST_MIN_SCAN;
            end
          endcase
        end
      end

      ST_ADD_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (proc) begin
          if (!valid_q[pidx]) begin
            if (!found_q) begin
              found_d = 1'b1;
              bidx_d  = pidx;
            end
          end else if (id_rd == cur_id_q) begin
            dup_d = 1'b1;
          end
        end
        if (scan_last) begin
          res_we = 1'b1;
          nres_d = ResCntW'(1);
          waddr  = bidx_d;
          if (found_d && !dup_d) begin
            exp_we          = 1'b1;
            int_we          = 1'b1;
            id_we           = 1'b1;
            valid_d[bidx_d] = 1'b1;
            res_wid         = cur_id_q;
          end else begin
            res_wstat = STAT_FULL;
          end
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = ST_MIN_SCAN;
        end
      end

      ST_CAN_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (proc && !found_q && valid_q[pidx] && (id_rd == cmd_q.tid)) begin
          found_d = 1'b1;
          bidx_d  = pidx;
        end
        if (scan_last) begin
          res_we  = 1'b1;
          nres_d  = ResCntW'(1);
          res_wid = cmd_q.tid;
          if (found_d) begin
            valid_d[bidx_d] = 1'b0;
          end else begin
            res_wstat = STAT_NOT_FOUND;
          end
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = ST_MIN_SCAN;
        end
      end

      ST_PICK_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        // strict compare keeps the lower slot on equal keys
        if (proc && elig && (!found_q || key_less)) begin
          found_d = 1'b1;
          bidx_d  = pidx;
          bexp_d  = exp_rd;
          bid_d   = id_rd;
          bint_d  = int_rd;
        end
        if (scan_last) begin
          cnt_d = '0;
          if (found_d) begin
            state_d = ST_PICK_DONE;
          end else begin
            if (nres_q == '0) begin
              res_we = 1'b1;
              nres_d = ResCntW'(1);
            end
            state_d = ST_MIN_SCAN;
          end
        end
      end

      ST_PICK_DONE: begin
        res_we           = 1'b1;
        res_wid          = bid_q;
        res_wkind        = KIND_EXPIRY;
        picked_d[bidx_q] = 1'b1;
        if (bint_q != '0) begin
          exp_we = 1'b1;
          exp_wd = rearm_sum[64] ? '1 : rearm_sum[63:0];
        end else begin
          valid_d[bidx_q] = 1'b0;
        end
        nres_d  = nres_q + ResCntW'(1);
        cnt_d   = '0;
        found_d = 1'b0;
        state_d = (nres_q == ResCntW'(MaxResults - 1)) ? ST_MIN_SCAN : ST_PICK_SCAN;
      end

      ST_MIN_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (proc && valid_q[pidx] && (!found_q || (exp_rd < bexp_q))) begin
          found_d = 1'b1;
          bexp_d  = exp_rd;
        end
        if (scan_last) begin
          armed_d = found_d;
          dl_d    = found_d ? bexp_d : '0;
          eidx_d  = '0;
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_vld_q || pop) begin
          out_ld = 1'b1;
          eidx_d = eidx_q + ResCntW'(1);
          if (out_last) begin
            // empty the list so the next step fills it from entry zero
            nres_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idc_q     <= 32'd1;
      valid_q   <= '0;
      picked_q  <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      dup_q     <= 1'b0;
      nres_q    <= '0;
      eidx_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idc_q    <= idc_d;
      valid_q  <= valid_d;
      picked_q <= picked_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      dup_q    <= dup_d;
      nres_q   <= nres_d;
      eidx_q   <= eidx_d;
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    cur_id_q <= cur_id_d;
    bidx_q   <= bidx_d;
    bexp_q   <= bexp_d;
    bint_q   <= bint_d;
    bid_q    <= bid_d;
    armed_q  <= armed_d;
    dl_q     <= dl_d;
    if (res_we) begin
      res_id_q[nres_q[ResIdxW-1:0]]   <= res_wid;
      res_kind_q[nres_q[ResIdxW-1:0]] <= res_wkind;
      res_stat_q[nres_q[ResIdxW-1:0]] <= res_wstat;
    end
    if (out_ld) begin
      out_id_q    <= res_id_q[eidx_q[ResIdxW-1:0]];
      out_kind_q  <= res_kind_q[eidx_q[ResIdxW-1:0]];
      out_stat_q  <= res_stat_q[eidx_q[ResIdxW-1:0]];
      out_last_q  <= out_last;
      out_armed_q <= armed_q;
      out_dl_q    <= dl_q;
    end
  end

  assign empty           = !out_vld_q;
  assign kind_o          = out_kind_q;
  assign status_o        = out_stat_q;
  assign result_id_o     = out_id_q;
  assign armed_o         = out_armed_q;
  assign next_deadline_o = out_dl_q;
  assign last_o          = out_last_q;

endmodule

@@ sv/timer_expiry_queue.sv @@
// ----------------------------------------------------------------------------
// timer_expiry_queue
// Table of DEPTH timers with add, cancel and tick; reports expiries in order.
// ----------------------------------------------------------------------------
// Before the first result word, add and cancel make one table scan and the
// deadline scan, an unknown opcode only the deadline scan; a tick repeats its
// pick scan until no due timer is left or the list of 16 is full, then makes
// the deadline scan. Throughput is one word at a time, bounded by the full-table
// scans through the single read port of the slot RAMs (one entry per cycle).
// Reset: all slots invalid, id counter at 1, queues empty; no clearing pass.
// ----------------------------------------------------------------------------
module timer_expiry_queue
  import teq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] timer_id_i,
  input  logic [63:0] expire_at_i,
  input  logic [63:0] repeat_interval_i,
  input  logic [63:0] now_time_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [1:0]  status_o,
  output logic [31:0] result_id_o,
  output logic        armed_o,
  output logic [63:0] next_deadline_o,
  output logic        last_o
);

  // front: decode and hold up to two words while the back is busy; full holds off the sender
  cmd_t cmd;
  logic cmd_vld, cmd_pop;

  teq_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .opcode_i, .timer_id_i, .expire_at_i, .repeat_interval_i, .now_time_i,
    .cmd_vld_o(cmd_vld), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  // back: scan the slot table per step, build the result list, then drain it
  // through a registered output word
  teq_back #(.DEPTH(DEPTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_vld_i(cmd_vld), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .empty, .pop,
    .kind_o, .status_o, .result_id_o, .armed_o, .next_deadline_o, .last_o
  );

endmodule

@@ tb/timer_expiry_queue_test.sv @@
// ----------------------------------------------------------------------------
// timer_expiry_queue_test
// Self-checking bench: drives add/cancel/tick/unknown words through the push queue and
// checks every popped result against a cycle-free model of the timer table.
// ----------------------------------------------------------------------------
module timer_expiry_queue_test;
  import teq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots   = 16;
  localparam logic [63:0] TimeMax = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic        kind;
    logic [1:0]  status;
    logic [31:0] id;
    logic        armed;
    logic [63:0] deadline;
    logic        last;
  } report_t;

  // One row of the directed table; typed rows carry the status part by hand.
  typedef struct {
    op_e         op;
    logic [31:0] tid;
    logic [63:0] exp;
    logic [63:0] intv;
    logic [63:0] now;
    int          rep;
    bit          typed;
    logic        kind;
    logic [1:0]  status;
    logic [31:0] id;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  opcode_i = '0;
  logic [31:0] timer_id_i = '0;
  logic [63:0] expire_at_i = '0;
  logic [63:0] repeat_interval_i = '0;
  logic [63:0] now_time_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind_o;
  logic [1:0]  status_o;
  logic [31:0] result_id_o;
  logic        armed_o;
  logic [63:0] next_deadline_o;
  logic        last_o;

  timer_expiry_queue #(.DEPTH(Slots)) dut (.*);

  always #2 clk_i = ~clk_i;

  // Shadow copy of the timer table.
  bit          tbl_valid [Slots];
  logic [63:0] tbl_expire[Slots];
  logic [63:0] tbl_intv  [Slots];
  logic [31:0] tbl_id    [Slots];
  logic [31:0] next_id;

  report_t pending_q[$];
  int      n_fail = 0;
  int      send_idle = 36;
  int      recv_idle = 47;

  // Earliest deadline still scheduled, zero when nothing is armed.
  function automatic logic [64:0] earliest_deadline();
    bit          any = 0;
    logic [63:0] best = '0;
    for (int i = 0; i < Slots; i++)
      if (tbl_valid[i] && (!any || tbl_expire[i] < best)) begin
        best = tbl_expire[i];
        any  = 1;
      end
    return {any, best};
  endfunction

  function automatic bit sorts_first(int a, int b);
    if (tbl_expire[a] != tbl_expire[b]) return tbl_expire[a] < tbl_expire[b];
    if (tbl_id[a] != tbl_id[b]) return tbl_id[a] < tbl_id[b];
    return a < b;
  endfunction

  // Apply one accepted word to the shadow table and queue the reports it causes.
  task automatic predict_reports(op_e op, logic [31:0] tid, logic [63:0] exp,
                                 logic [63:0] intv, logic [63:0] now,
                                 bit typed, report_t hand);
    report_t     r[$];
    report_t     one;
    logic [31:0] id;
    logic [63:0] t;
    logic [64:0] dl;
    int          free_slot;
    int          best;
    bit          dup;
    bit          picked[Slots];
    one = '{default: '0};
    case (op)
      OP_ADD: begin
        id = next_id;
        next_id = next_id + 1;
        if (next_id == 0) next_id = 1;
        free_slot = -1;
        dup = 0;
        for (int i = 0; i < Slots; i++)
          if (!tbl_valid[i]) begin
            if (free_slot < 0) free_slot = i;
          end else if (tbl_id[i] == id) dup = 1;
        if (free_slot < 0 || dup) begin
          one.status = STAT_FULL;
        end else begin
          tbl_valid[free_slot]  = 1;
          tbl_expire[free_slot] = exp;
          tbl_intv[free_slot]   = intv;
          tbl_id[free_slot]     = id;
          one.id = id;
        end
        r.insert(r.size(), one);
      end
      OP_CANCEL: begin
        one.status = STAT_NOT_FOUND;
        one.id = tid;
        for (int i = 0; i < Slots; i++)
          if (tbl_valid[i] && tbl_id[i] == tid) begin
            tbl_valid[i] = 0;
            one.status = STAT_OK;
            break;
          end
        r.insert(r.size(), one);
      end
      OP_TICK: begin
        picked = '{default: 0};
        // Pick the due timers first (up to MaxResults), then re-arm, so the order uses old keys.
        while (r.size() < MaxResults) begin
          best = -1;
          for (int i = 0; i < Slots; i++)
            if (tbl_valid[i] && !picked[i] && tbl_expire[i] <= now &&
                (best < 0 || sorts_first(i, best)))
              best = i;
          if (best < 0) break;
          picked[best] = 1;
          one.kind = KIND_EXPIRY;
          one.id = tbl_id[best];
          r.insert(r.size(), one);
        end
        for (int i = 0; i < Slots; i++)
          if (picked[i]) begin
            if (tbl_intv[i] != 0) begin
              t = now + tbl_intv[i];
              tbl_expire[i] = (t < now) ? TimeMax : t;
            end else begin
              tbl_valid[i] = 0;
            end
          end
        if (r.size() == 0) r.insert(r.size(), one);
      end
      default: r.insert(r.size(), one);
    endcase
    if (typed) begin
      r[0].kind = hand.kind;
      r[0].status = hand.status;
      r[0].id = hand.id;
    end
    dl = earliest_deadline();
    foreach (r[k]) begin
      r[k].armed = dl[64];
      r[k].deadline = dl[63:0];
      r[k].last = (k == r.size() - 1);
      pending_q.insert(pending_q.size(), r[k]);
    end
  endtask

  // Offer one word at falling edges until a rising edge accepts it.
  task automatic send_word(op_e op, logic [31:0] tid, logic [63:0] exp,
                           logic [63:0] intv, logic [63:0] now,
                           bit typed, report_t hand);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(99) < send_idle) begin
        push = 1'b0;
      end else begin
        push = 1'b1;
        opcode_i = op;
        timer_id_i = tid;
        expire_at_i = exp;
        repeat_interval_i = intv;
        now_time_i = now;
      end
      @(posedge clk_i);
      if (push && !full) begin
        predict_reports(op, tid, exp, intv, now, typed, hand);
        break;
      end
    end
  endtask

  // Stall the result side at random.
  always @(negedge clk_i) pop <= ($urandom_range(99) >= recv_idle);

  // Check each popped word against the oldest expectation.
  always @(posedge clk_i) begin
    report_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result word id=%0d", result_id_o);
        n_fail++;
      end else begin
        e = pending_q.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind_o); n_fail++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o); n_fail++;
        end
        if (result_id_o !== e.id) begin
          $error("result_id: expected %0d, got %0d", e.id, result_id_o); n_fail++;
        end
        if (armed_o !== e.armed) begin
          $error("armed: expected %0d, got %0d", e.armed, armed_o); n_fail++;
        end
        if (next_deadline_o !== e.deadline) begin
          $error("next_deadline: expected %0h, got %0h", e.deadline, next_deadline_o);
          n_fail++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last_o); n_fail++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Hard limit on the whole run.
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    row_t        rows[$];
    report_t     hand;
    logic [63:0] t_base;
    logic [63:0] exp, intv, now;
    logic [31:0] tid;
    int          pick, live[$];
    op_e         op;

    next_id = 1;
    tbl_valid = '{default: 0};
    hand = '{default: '0};

    // Directed table: empty-table errors and quiet tick, saturating re-arm,
    // fill to full, a wide tick, then drain.
    rows = '{
      '{OP_CANCEL, 32'd5,        0,        0,       0,       1, 1, 0, STAT_NOT_FOUND, 5},
      '{OP_TICK,   0,            0,        0,       0,       1, 1, 0, STAT_OK, 0},
      '{OP_NONE,   '1,           '1,       '1,      '1,      1, 1, 0, STAT_OK, 0},
      '{OP_ADD,    0,            64'd100,  0,       0,       1, 1, 0, STAT_OK, 1},
      '{OP_ADD,    0,            0,        64'd50,  0,       1, 1, 0, STAT_OK, 2},
      '{OP_ADD,    0,            TimeMax,  TimeMax, 0,       1, 1, 0, STAT_OK, 3},
      '{OP_TICK,   0,            0,        0,       0,       1, 0, 0, 0, 0},
      '{OP_TICK,   0,            0,        0,       TimeMax, 1, 0, 0, 0, 0},
      '{OP_CANCEL, 32'd3,        0,        0,       0,       1, 1, 0, STAT_OK, 3},
      '{OP_CANCEL, 32'hFFFFFFFF, 0,        0,       0,       1, 1, 0, STAT_NOT_FOUND, '1},
      '{OP_ADD,    0,            64'd500,  0,       0,      15, 0, 0, 0, 0},
      '{OP_ADD,    0,            64'd7,    64'd7,   0,       1, 1, 0, STAT_FULL, 0},
      '{OP_TICK,   0,            0,        0,       64'd500, 1, 0, 0, 0, 0},
      '{OP_TICK,   0,            0,        0,       TimeMax, 1, 0, 0, 0, 0},
      '{OP_CANCEL, 32'd2,        0,        0,       0,       1, 1, 0, STAT_OK, 2}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[k])
      repeat (rows[k].rep) begin
        hand.kind = rows[k].kind;
        hand.status = rows[k].status;
        hand.id = rows[k].id;
        send_word(rows[k].op, rows[k].tid, rows[k].exp, rows[k].intv, rows[k].now,
                  rows[k].typed, hand);
      end

    // Random part in three idling phases: receiver-heavy, sender-heavy, none.
    t_base = 64'd1000;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 36 : (ph == 1) ? 47 : 0;
      recv_idle = (ph == 0) ? 47 : (ph == 1) ? 36 : 0;
      repeat (40) begin
        pick = $urandom_range(99);
        op = (pick < 40) ? OP_ADD : (pick < 60) ? OP_CANCEL :
             (pick < 95) ? OP_TICK : OP_NONE;
        exp = t_base + $urandom_range(300);
        intv = $urandom_range(1) ? 64'd0 : 64'($urandom_range(1, 300));
        now = t_base;
        tid = $urandom;
        if ($urandom_range(19) == 0) exp = rand64();
        if ($urandom_range(19) == 0) intv = rand64();
        // Cancel a live timer most of the time, otherwise any id at all.
        live.delete();
        for (int i = 0; i < Slots; i++) if (tbl_valid[i]) live.insert(live.size(), tbl_id[i]);
        if (op == OP_CANCEL && live.size() > 0 && $urandom_range(3) != 0)
          tid = live[$urandom_range(live.size() - 1)];
        if (op == OP_TICK) begin
          t_base = t_base + $urandom_range(200);
          now = ($urandom_range(19) == 0) ? rand64() : t_base;
        end
        send_word(op, tid, exp, intv, now, 0, hand);
      end
    end
    @(negedge clk_i);
    push = 1'b0;

    // Drain, then leave room for a late stray word.
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
